[rtl/assert_macros.svh]
// Assertion macros shared by the state machine unit RTL.
// Depends on: a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active
`define TDSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define TDSM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/tdsm_pkg.sv]
// Package for the table-driven state machine unit: sizes, codes and types.
// Depends on: nothing.
package tdsm_pkg;

    // Table geometry
    localparam int ENTRIES   = 16;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    // Field widths
    localparam int STATE_W   = 16;
    localparam int EVENT_W   = 16;
    localparam int OP_W      = 2;
    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // Width for comparing entry counts and slot numbers against the table size
    localparam int LIM_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SLOT_CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    // Operation codes of an input word
    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_EVENT = 2'd2
    } op_e;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_STATE = 1'b0,
        CFG_ENTRY_COUNT   = 1'b1
    } cfg_reg_e;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } ctrl_state_t;

    // One transition table entry
    typedef struct packed {
        logic [STATE_W-1:0] src_state;
        logic [EVENT_W-1:0] evt;
        logic [STATE_W-1:0] dst_state;
    } entry_t;

    // Table write port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } tbl_wr_t;

    // Table read port request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } tbl_rd_t;

endpackage

[rtl/tdsm_ifs.sv]
// Valid/ready channel interfaces of the state machine unit: item, result, config.
// Depends on: tdsm_pkg.

// Input item channel
interface tdsm_req_if;
    logic                           valid;
    logic                           ready;
    logic [tdsm_pkg::OP_W-1:0]      operation;
    logic [tdsm_pkg::SLOT_W-1:0]    entry_index;
    logic [tdsm_pkg::STATE_W-1:0]   entry_from_state;
    logic [tdsm_pkg::EVENT_W-1:0]   entry_event;
    logic [tdsm_pkg::STATE_W-1:0]   entry_to_state;
    logic [tdsm_pkg::EVENT_W-1:0]   event_id;

    modport source (
        output valid, operation, entry_index, entry_from_state, entry_event,
               entry_to_state, event_id,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, entry_from_state, entry_event,
               entry_to_state, event_id,
        output ready
    );
endinterface

// Result channel
interface tdsm_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           status;
    logic [tdsm_pkg::STATE_W-1:0]   current_state_out;
    logic [tdsm_pkg::SLOT_W-1:0]    matched_index;
    logic                           fired;

    modport source (
        output valid, status, current_state_out, matched_index, fired,
        input  ready
    );
    modport sink (
        input  valid, status, current_state_out, matched_index, fired,
        output ready
    );
endinterface

// Configuration write channel
interface tdsm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tdsm_pkg::CFG_IDX_W-1:0]    index;
    logic [tdsm_pkg::CFG_DATA_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[rtl/tdsm_table_ram.sv]
// Transition table memory: one write port, one read port with registered data.
// Depends on: tdsm_pkg.
module tdsm_table_ram (
    input  logic             clk,
    input  tdsm_pkg::tbl_wr_t wr,
    input  tdsm_pkg::tbl_rd_t rd,
    output tdsm_pkg::entry_t  rd_data
);
    import tdsm_pkg::*;

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    // Write and registered read; contents undefined until loaded
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/tdsm_ctrl.sv]
// Sequencer of the state machine unit: takes items, scans the table memory,
// holds the current state and configuration, and registers the result word.
// Depends on: tdsm_pkg, tdsm_ifs, assert_macros.svh.
module tdsm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    tdsm_req_if.sink          req,
    tdsm_rsp_if.source        rsp,
    tdsm_cfg_if.sink          cfg,
    output tdsm_pkg::tbl_wr_t tbl_wr,
    output tdsm_pkg::tbl_rd_t tbl_rd,
    input  tdsm_pkg::entry_t  tbl_rd_data
);
    import tdsm_pkg::*;

    ctrl_state_t          state_reg, state_next;

    logic [STATE_W-1:0]   cur_state_reg;
    logic [STATE_W-1:0]   init_state_reg;
    logic [COUNT_W-1:0]   entry_count_reg;
    logic [EVENT_W-1:0]   event_reg;
    logic [IDX_W-1:0]     scan_idx_reg;

    logic                 res_status_reg;
    logic                 res_fired_reg;
    logic [IDX_W-1:0]     res_idx_reg;

    logic                 out_valid_reg;
    logic                 out_status_reg;
    logic [STATE_W-1:0]   out_state_reg;
    logic [SLOT_W-1:0]    out_idx_reg;
    logic                 out_fired_reg;

    logic                 accept;
    logic                 out_free;
    logic [LIM_W-1:0]     limit;
    logic                 hit;
    logic                 last;
    logic                 slot_ok;

    // Effective lookup bound: entry count clipped to the table size
    always_comb
    begin
        if (LIM_W'(entry_count_reg) > LIM_W'(ENTRIES))
        begin
            limit = LIM_W'(ENTRIES);
        end
        else
        begin
            limit = LIM_W'(entry_count_reg);
        end
    end

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign hit      = (tbl_rd_data.src_state == cur_state_reg) &&
                      (tbl_rd_data.evt == event_reg);
    assign last     = (LIM_W'(scan_idx_reg) + LIM_W'(1)) == limit;
    assign slot_ok  = SLOT_CMP_W'(req.entry_index) < SLOT_CMP_W'(ENTRIES);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((req.operation == OP_EVENT) && (limit != '0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit || last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and memory port control
    always_comb
    begin
        req.ready        = 1'b0;
        tbl_wr.en        = 1'b0;
        tbl_wr.addr      = IDX_W'(req.entry_index);
        tbl_wr.data      = '{src_state: req.entry_from_state,
                             evt:       req.entry_event,
                             dst_state: req.entry_to_state};
        tbl_rd.en        = 1'b0;
        tbl_rd.addr      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                // ready is high here, so valid alone marks an accepted word
                req.ready   = 1'b1;
                tbl_wr.en   = req.valid && (req.operation == OP_LOAD) && slot_ok;
                tbl_rd.en   = req.valid && (req.operation == OP_EVENT);
                tbl_rd.addr = '0;
            end
            ST_SCAN:
            begin
                // Fetch the next entry while this one is compared
                tbl_rd.en   = !hit && !last;
                tbl_rd.addr = scan_idx_reg + 1'b1;
            end
            ST_DONE:
            begin
                req.ready   = 1'b0;
            end
            default:
            begin
                req.ready   = 1'b0;
            end
        endcase
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_state_reg  <= '0;
            entry_count_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_INITIAL_STATE: init_state_reg  <= cfg.data;
                CFG_ENTRY_COUNT:   entry_count_reg <= cfg.data[COUNT_W-1:0];
                default:           init_state_reg  <= init_state_reg;
            endcase
        end
    end

    // Current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_state_reg <= '0;
        end
        else if (state_reg == ST_IDLE && accept && req.operation == OP_START)
        begin
            cur_state_reg <= init_state_reg;
        end
        else if (state_reg == ST_SCAN && hit)
        begin
            cur_state_reg <= tbl_rd_data.dst_state;
        end
    end

    // Scan index and pending result
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    event_reg      <= req.event_id;
                    scan_idx_reg   <= '0;
                    res_fired_reg  <= 1'b0;
                    res_idx_reg    <= '0;
                    res_status_reg <= (req.operation == OP_EVENT) && (limit == '0);
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    res_fired_reg <= 1'b1;
                    res_idx_reg   <= scan_idx_reg;
                end
                else if (last)
                begin
                    res_status_reg <= 1'b1;
                end
                else
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end
            default:
            begin
                scan_idx_reg <= scan_idx_reg;
            end
        endcase
    end

    // Result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_state_reg  <= cur_state_reg;
            out_idx_reg    <= SLOT_W'(res_idx_reg);
            out_fired_reg  <= res_fired_reg;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.status            = out_status_reg;
    assign rsp.current_state_out = out_state_reg;
    assign rsp.matched_index     = out_idx_reg;
    assign rsp.fired             = out_fired_reg;

    // Checks
    `include "assert_macros.svh"

    `TDSM_ASSERT(a_scan_in_range, (state_reg == ST_SCAN) |-> (LIM_W'(scan_idx_reg) < limit), "scan index past entry count")
    `TDSM_ASSERT(a_write_idle_only, tbl_wr.en |-> (state_reg == ST_IDLE), "table written outside idle")
    `TDSM_ASSERT(a_done_drains, (state_reg == ST_DONE && !out_valid_reg) |=> (state_reg == ST_IDLE && out_valid_reg), "finished result not moved to output")
    `TDSM_ASSERT(a_fired_ok, (out_valid_reg && out_fired_reg) |-> !out_status_reg, "fired result with error status")

endmodule

[rtl/table_driven_state_machine_unit.sv]
// Top level of the table-driven state machine unit.
// Depends on: tdsm_pkg, tdsm_ifs, tdsm_table_ram, tdsm_ctrl.
//
// A programmable state machine with a 16-entry transition table held in a
// synchronous memory. A load word writes one entry, a start word sets the
// state to the initial_state register, an event word scans entries 0 up to
// entry_count-1 (entry_count clipped to 16) and takes the first whose from
// state and event match. Each input word gives one result word. An event
// word reads entries in order up to and including the match (or up to the
// clipped entry count when nothing matches); the single table read port
// delivers one entry per cycle. One word is processed at a time; a new word
// is taken while the previous result still waits in the output register.
// The table has no reset: entries must be loaded before a lookup reaches
// them. Configuration writes are taken at any time and must only be made
// while the unit is idle.
module table_driven_state_machine_unit (
    input  logic       clk,
    input  logic       rst_n,
    tdsm_req_if.sink   req,
    tdsm_rsp_if.source rsp,
    tdsm_cfg_if.sink   cfg
);
    import tdsm_pkg::*;

    tbl_wr_t tbl_wr;
    tbl_rd_t tbl_rd;
    entry_t  tbl_rd_data;

    // Sequencer
    tdsm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg         (cfg),
        .tbl_wr      (tbl_wr),
        .tbl_rd      (tbl_rd),
        .tbl_rd_data (tbl_rd_data)
    );

    // Transition table
    tdsm_table_ram u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd      (tbl_rd),
        .rd_data (tbl_rd_data)
    );

endmodule

[sim/tb.sv]
// Self-checking bench for table_driven_state_machine_unit: load, start and event words.
// Depends on: tdsm_pkg, tdsm_ifs (req, rsp and cfg channels), the unit's RTL.
// A shadow copy of the machine predicts every result word; the results are checked in order.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tdsm_pkg::*;

    // Bench constants
    localparam logic [OP_W-1:0] OP_UNUSED       = 2'd3;
    localparam logic            STATUS_OK       = 1'b0;
    localparam logic            STATUS_NO_MATCH = 1'b1;
    localparam int IDLE_PCT      = 38;
    localparam int HOLD_CYCLES   = 120;
    localparam int PHASE_WORDS   = 50;
    localparam int RANDOM_PHASES = 8;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;

    // One input word and one result word
    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [SLOT_W-1:0]  entry_index;
        logic [STATE_W-1:0] entry_from_state;
        logic [EVENT_W-1:0] entry_event;
        logic [STATE_W-1:0] entry_to_state;
        logic [EVENT_W-1:0] event_id;
    } fsm_word_t;

    typedef struct packed {
        logic               status;
        logic [STATE_W-1:0] state;
        logic [SLOT_W-1:0]  matched_index;
        logic               fired;
    } fsm_result_t;

    // Shadow of the machine: current state, transition slots and registers
    typedef struct {
        logic [STATE_W-1:0] cur_state;
        entry_t             slots [ENTRIES];
        logic [STATE_W-1:0] init_state;
        logic [COUNT_W-1:0] count;
    } fsm_shadow_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;

    tdsm_req_if req_ch ();
    tdsm_rsp_if rsp_ch ();
    tdsm_cfg_if cfg_ch ();

    table_driven_state_machine_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #1 clk = ~clk;

    fsm_shadow_t check_model;   // follows accepted words
    fsm_shadow_t gen_model;     // follows queued words, steers the stimulus
    fsm_word_t   pending_words [$];
    fsm_result_t expected_results [$];
    fsm_word_t   tx_word;

    int tx_idle_pct = IDLE_PCT;
    int rx_idle_pct = IDLE_PCT;
    int rx_holds_asked = 0;
    int rx_holds_served = 0;
    int rx_hold_left = 0;

    int unsigned cycles = 0;
    int words_queued = 0;
    int results_checked = 0;
    int transitions_seen = 0;
    int misses_seen = 0;
    int settings_used = 0;
    int mismatches = 0;

    // Predict the result of one word and advance the shadow
    function automatic fsm_result_t step_fsm(inout fsm_shadow_t m, input fsm_word_t w);
        fsm_result_t r;
        int          lim;
        r = '0;
        r.status = STATUS_OK;
        lim = (int'(m.count) > ENTRIES) ? ENTRIES : int'(m.count);
        case (w.operation)
            OP_LOAD:
                m.slots[w.entry_index] = {w.entry_from_state, w.entry_event, w.entry_to_state};
            OP_START:
                m.cur_state = m.init_state;
            OP_EVENT:
            begin
                r.status = STATUS_NO_MATCH;
                // first matching slot wins
                for (int i = 0; i < lim; i++) begin
                    if (r.status == STATUS_NO_MATCH && m.slots[i].src_state == m.cur_state &&
                        m.slots[i].evt == w.event_id) begin
                        r.status = STATUS_OK;
                        r.fired = 1'b1;
                        r.matched_index = SLOT_W'(i);
                        m.cur_state = m.slots[i].dst_state;
                    end
                end
            end
            default: ;
        endcase
        r.state = m.cur_state;
        return r;
    endfunction

    function automatic fsm_word_t make_word(logic [OP_W-1:0] op, logic [SLOT_W-1:0] idx,
                                            logic [STATE_W-1:0] from_st,
                                            logic [EVENT_W-1:0] ev,
                                            logic [STATE_W-1:0] to_st,
                                            logic [EVENT_W-1:0] id);
        fsm_word_t w;
        w = {op, idx, from_st, ev, to_st, id};
        return w;
    endfunction

    // States drawn from a small pool so that loaded slots chain into each other
    function automatic logic [STATE_W-1:0] pool_state();
        logic [STATE_W-1:0] s;
        case ($urandom_range(5))
            4:       s = gen_model.init_state;
            5:       s = 16'hFFFF;
            default: s = STATE_W'($urandom_range(3));
        endcase
        return s;
    endfunction

    // Mostly events that hit a slot of the current state, plus starts, loads and noise
    function automatic fsm_word_t random_word();
        fsm_word_t w;
        int        pick;
        int        lim;
        int        hits [$];
        w = make_word(OP_W'($urandom), SLOT_W'($urandom), STATE_W'($urandom),
                      EVENT_W'($urandom), STATE_W'($urandom), EVENT_W'($urandom));
        pick = $urandom_range(99);
        lim = (int'(gen_model.count) > ENTRIES) ? ENTRIES : int'(gen_model.count);
        if (pick < 68) begin
            w.operation = OP_EVENT;
            for (int i = 0; i < lim; i++) begin
                if (gen_model.slots[i].src_state == gen_model.cur_state)
                    hits.push_back(i);
            end
            if (hits.size() != 0)
                w.event_id = gen_model.slots[hits[$urandom_range(hits.size() - 1)]].evt;
            else if ($urandom_range(1) != 0)
                w.event_id = EVENT_W'($urandom_range(7));
        end else if (pick < 80) begin
            w.operation = OP_EVENT;
        end else if (pick < 88) begin
            w.operation = OP_START;
        end else if (pick < 98) begin
            w.operation = OP_LOAD;
            if ($urandom_range(7) != 0) begin
                w.entry_from_state = pool_state();
                w.entry_event = EVENT_W'($urandom_range(7));
                w.entry_to_state = pool_state();
            end
        end else begin
            w.operation = OP_UNUSED;
        end
        return w;
    endfunction

    task automatic push_word(input fsm_word_t w);
        void'(step_fsm(gen_model, w));
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Sender paused until every queued word has its result back
    task automatic wait_drained();
        while (results_checked < words_queued)
            @(posedge clk);
    endtask

    // Write both registers back to back; only called while the unit is idle
    task automatic program_regs(input logic [STATE_W-1:0] init_st,
                                input logic [COUNT_W-1:0] count);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_INITIAL_STATE;
        cfg_ch.data  <= init_st;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        check_model.init_state = init_st;
        gen_model.init_state = init_st;
        cfg_ch.index <= CFG_ENTRY_COUNT;
        cfg_ch.data  <= CFG_DATA_W'(count);
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        check_model.count = count;
        gen_model.count = count;
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic flag_mismatch(input string what, input fsm_result_t want,
                                 input fsm_result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: expected st=%0d state=%h idx=%0d fired=%0d, got st=%0d state=%h idx=%0d fired=%0d",
                     $realtime, what, want.status, want.state, want.matched_index, want.fired,
                     got.status, got.state, got.matched_index, got.fired);
    endtask

    // Driver: offers queued words, idling at random between them
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_ch.valid            <= 1'b0;
            req_ch.operation        <= '0;
            req_ch.entry_index      <= '0;
            req_ch.entry_from_state <= '0;
            req_ch.entry_event      <= '0;
            req_ch.entry_to_state   <= '0;
            req_ch.event_id         <= '0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                tx_word = pending_words.pop_front();
                req_ch.valid            <= 1'b1;
                req_ch.operation        <= tx_word.operation;
                req_ch.entry_index      <= tx_word.entry_index;
                req_ch.entry_from_state <= tx_word.entry_from_state;
                req_ch.entry_event      <= tx_word.entry_event;
                req_ch.entry_to_state   <= tx_word.entry_to_state;
                req_ch.event_id         <= tx_word.event_id;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus long holds on request
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            rx_hold_left <= 0;
        end else if (rx_hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_holds_served != rx_holds_asked) begin
            rsp_ch.ready    <= 1'b0;
            rx_hold_left    <= HOLD_CYCLES;
            rx_holds_served <= rx_holds_served + 1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: predict on accepted words, check accepted results in order
    always @(posedge clk) begin
        fsm_word_t   w;
        fsm_result_t got;
        fsm_result_t want;
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                w = make_word(req_ch.operation, req_ch.entry_index, req_ch.entry_from_state,
                              req_ch.entry_event, req_ch.entry_to_state, req_ch.event_id);
                expected_results.push_back(step_fsm(check_model, w));
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = {rsp_ch.status, rsp_ch.current_state_out, rsp_ch.matched_index,
                       rsp_ch.fired};
                if (expected_results.size() == 0) begin
                    flag_mismatch("result with no word outstanding", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (want.fired)
                        transitions_seen++;
                    if (want.status == STATUS_NO_MATCH)
                        misses_seen++;
                    if (got.status !== want.status || got.state !== want.state ||
                        got.matched_index !== want.matched_index || got.fired !== want.fired)
                        flag_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        logic [STATE_W-1:0] init_st;
        logic [COUNT_W-1:0] count;

        check_model.cur_state = '0;
        check_model.init_state = '0;
        check_model.count = '0;
        for (int i = 0; i < ENTRIES; i++)
            check_model.slots[i] = '0;
        gen_model = check_model;

        rst_n        <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_INITIAL_STATE;
        cfg_ch.data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: lookup over zero slots, unused code, start
        push_word(make_word(OP_EVENT, 4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        push_word(make_word(OP_UNUSED, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        push_word(make_word(OP_START, 4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        // Fill every slot before any lookup can reach one
        push_word(make_word(OP_LOAD, 4'd0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000));
        push_word(make_word(OP_LOAD, 4'd1, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
        for (int i = 2; i < ENTRIES - 1; i++)
            push_word(make_word(OP_LOAD, SLOT_W'(i), (i == 2) ? 16'h0000 : STATE_W'(i - 1),
                                EVENT_W'(16'h00A0 + i), STATE_W'(i), 16'h0000));
        // duplicate of slot 0 at the end: the lower slot has to win
        push_word(make_word(OP_LOAD, 4'd15, 16'h0000, 16'hFFFF, 16'h1234, 16'h0000));
        wait_drained();

        // Full table, initial state at the top of the range
        program_regs(16'hFFFF, 5'd16);
        push_word(make_word(OP_START, 4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        push_word(make_word(OP_EVENT, 4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        push_word(make_word(OP_EVENT, 4'd0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
        push_word(make_word(OP_EVENT, 4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h1234));
        wait_drained();

        // Random phases, each with its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       begin init_st = 16'h0000;               count = 5'd16; end
                1:       begin init_st = 16'hFFFF;               count = 5'd31; end
                2:       begin init_st = STATE_W'($urandom);     count = 5'd0;  end
                3:       begin init_st = 16'h0000;               count = 5'd1;  end
                4:       begin init_st = STATE_W'($urandom);     count = COUNT_W'($urandom_range(16)); end
                5:       begin init_st = STATE_W'($urandom_range(3)); count = 5'd16; end
                6:       begin init_st = 16'hFFFF;               count = COUNT_W'($urandom_range(2, 15)); end
                default: begin init_st = STATE_W'($urandom);     count = 5'd16; end
            endcase
            program_regs(init_st, count);
            // one stretch without any idling on either side
            tx_idle_pct = (p == 5) ? 0 : IDLE_PCT;
            rx_idle_pct = (p == 5) ? 0 : IDLE_PCT;
            // long receiver hold while the sender keeps offering
            if (p == 0)
                rx_holds_asked++;
            push_word(make_word(OP_START, SLOT_W'($urandom), STATE_W'($urandom),
                                EVENT_W'($urandom), STATE_W'($urandom), EVENT_W'($urandom)));
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (p == 3 && k == PHASE_WORDS / 2)
                    wait_drained();
                push_word(random_word());
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d words under %0d register settings; %0d transitions taken, %0d lookups missed.",
                 words_queued, settings_used, transitions_seen, misses_seen);
        $display("Checked %0d result words, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
